/* hdl/bci_pkg.sv */
// shared constants for the bicubic 4x4 interpolator
// no dependencies; imported by the top level
`default_nettype none

package bci_pkg;

	// default sample and fraction widths
	localparam int SAMPLE_BITS_DEF = 8;
	localparam int FRAC_BITS_DEF   = 8;

	// fraction bits kept on each row result between the two passes
	localparam int ROW_FRAC = 8;

	// window size and pipeline depth
	localparam int TAPS       = 4;
	localparam int NUM_STAGES = 8;

endpackage

`default_nettype wire

/* hdl/bicubic_4x4_interpolator.sv */
// catmull-rom bicubic interpolator over a 4x4 window, eight-stage pipeline
// depends on bci_pkg for default widths, row precision and stage count
`default_nettype none

// One beat in carries a 4x4 window of unsigned samples, four per row with the
// leftmost sample in the lowest bits, plus x and y fractions (value over
// 2^FRAC_BITS). Each row is run through the catmull-rom cubic (a = -0.5) with
// the x fraction and floored to a signed value with ROW_FRAC fraction bits;
// the four row results then go through the same cubic with the y fraction,
// are floored to an integer and clamped to 0..2^SAMPLE_BITS-1. The cubic is
// evaluated exactly in integers by Horner's rule on the fraction, one
// multiply-add per stage: stage 1 forms the polynomial coefficients of all
// four rows, stages 2-4 do the three horizontal multiply-adds, stage 5 forms
// the vertical coefficients, stages 6-8 do the vertical multiply-adds, and
// stage 8 also clamps into the output register. Throughput is one pixel per
// clock while the output side is not stalled. Each stage has its own valid
// bit and holds its data while the stage after it is full and cannot move on,
// so bubbles are squeezed out and the block keeps taking input while a
// finished pixel waits to be read. There is no state between pixels and no
// configuration.
module bicubic_4x4_interpolator
	import bci_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// input beat
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// fields from bit 0 up: row_0, row_1, row_2, row_3, x_frac, y_frac, zero fill
	input  wire logic [((16*SAMPLE_BITS + 2*FRAC_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// output beat
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// fields from bit 0 up: pixel, zero fill
	output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

	localparam int S = SAMPLE_BITS;
	localparam int F = FRAC_BITS;
	localparam int R = ROW_FRAC;
	localparam int NST = NUM_STAGES;
	localparam int OUT_W = ((S + 7) / 8) * 8;

	// horizontal pass widths: signed sample, coefficients, horner partials
	localparam int HN = S + 1;
	localparam int HC = HN + 4;
	localparam int HA = HN + F + 5;
	localparam int HB = HN + 2*F + 6;
	localparam int HE = HN + 3*F + 7;

	// vertical pass widths, the row result is the sample here
	localparam int VN = S + R + 2;
	localparam int VC = VN + 4;
	localparam int VA = VN + F + 5;
	localparam int VB = VN + 2*F + 6;
	localparam int VE = VN + 3*F + 7;

	// cubic sums carry a scale of 2^(3F+1)
	localparam int H_SHIFT = 3*F + 1 - R;
	localparam int V_SHIFT = 3*F + 1 + R;

	localparam logic [S-1:0] PIX_MAX = '1;

	// ------------------------------------------------------------------
	// stage handshake: a stage loads when it is empty or its data moves on
	// ------------------------------------------------------------------
	logic [NST:1]   vld_q;
	logic [NST:1]   vld_in;
	logic [NST+1:1] rdy;

	always_comb begin
		rdy[NST+1] = m_axis_tready;
		for (int k = 1; k <= NST; k++) begin
			// ready when the sink takes a beat or some stage from k on is empty
			rdy[k] = m_axis_tready || (|(~vld_q >> (k - 1)));
		end
	end

	assign vld_in = {vld_q[NST-1:1], s_axis_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~rdy[NST:1]) | (vld_in & rdy[NST:1]);
		end
	end

	assign s_axis_tready = rdy[1];
	assign m_axis_tvalid = vld_q[NST];

	// ------------------------------------------------------------------
	// stage 1: unpack the window, form horizontal coefficients per row
	// ------------------------------------------------------------------
	logic signed [HC-1:0] hx      [TAPS][TAPS];
	logic signed [HC-1:0] hc1_d   [TAPS];
	logic signed [HC-1:0] hc2_d   [TAPS];
	logic signed [HC-1:0] hc3_d   [TAPS];

	logic signed [HC-1:0] hc1_s1  [TAPS];
	logic signed [HC-1:0] hc2_s1  [TAPS];
	logic signed [HC-1:0] hc3_s1  [TAPS];
	logic signed [HN-1:0] hs1_s1  [TAPS];
	logic [F-1:0]         fx_s1;
	logic [F-1:0]         fy_s1;

	always_comb begin
		for (int r = 0; r < TAPS; r++) begin
			for (int j = 0; j < TAPS; j++) begin
				// unsigned sample zero extended into the signed coefficient width
				hx[r][j] = $signed({{(HC-S){1'b0}}, s_axis_tdata[r*TAPS*S + j*S +: S]});
			end
			// cubic = 2*s1*D^3 + c1*f*D^2 + c2*f^2*D + c3*f^3
			hc1_d[r] = hx[r][2] - hx[r][0];
			hc2_d[r] = (hx[r][0] <<< 1) - (hx[r][1] <<< 2) - hx[r][1]
			           + (hx[r][2] <<< 2) - hx[r][3];
			hc3_d[r] = hx[r][1] + (hx[r][1] <<< 1) - hx[r][0]
			           - hx[r][2] - (hx[r][2] <<< 1) + hx[r][3];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1] && vld_in[1]) begin
			for (int r = 0; r < TAPS; r++) begin
				hc1_s1[r] <= hc1_d[r];
				hc2_s1[r] <= hc2_d[r];
				hc3_s1[r] <= hc3_d[r];
				hs1_s1[r] <= $signed({1'b0, s_axis_tdata[r*TAPS*S + S +: S]});
			end
			fx_s1 <= s_axis_tdata[16*S +: F];
			fy_s1 <= s_axis_tdata[16*S + F +: F];
		end
	end

	// ------------------------------------------------------------------
	// stage 2: a = c3*f + c2*D
	// ------------------------------------------------------------------
	logic signed [F:0]    fxs_1;
	logic signed [HA-1:0] hpa_d  [TAPS];
	logic signed [HA-1:0] ha_d   [TAPS];

	logic signed [HA-1:0] ha_s2  [TAPS];
	logic signed [HC-1:0] hc1_s2 [TAPS];
	logic signed [HN-1:0] hs1_s2 [TAPS];
	logic [F-1:0]         fx_s2;
	logic [F-1:0]         fy_s2;

	assign fxs_1 = $signed({1'b0, fx_s1});

	always_comb begin
		for (int r = 0; r < TAPS; r++) begin
			hpa_d[r] = hc3_s1[r] * fxs_1;
			ha_d[r]  = hpa_d[r] + ($signed({{(HA-HC){hc2_s1[r][HC-1]}}, hc2_s1[r]}) <<< F);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2] && vld_in[2]) begin
			for (int r = 0; r < TAPS; r++) begin
				ha_s2[r]  <= ha_d[r];
				hc1_s2[r] <= hc1_s1[r];
				hs1_s2[r] <= hs1_s1[r];
			end
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: b = a*f + c1*D^2
	// ------------------------------------------------------------------
	logic signed [F:0]    fxs_2;
	logic signed [HB-1:0] hpb_d  [TAPS];
	logic signed [HB-1:0] hb_d   [TAPS];

	logic signed [HB-1:0] hb_s3  [TAPS];
	logic signed [HN-1:0] hs1_s3 [TAPS];
	logic [F-1:0]         fx_s3;
	logic [F-1:0]         fy_s3;

	assign fxs_2 = $signed({1'b0, fx_s2});

	always_comb begin
		for (int r = 0; r < TAPS; r++) begin
			hpb_d[r] = ha_s2[r] * fxs_2;
			hb_d[r]  = hpb_d[r]
			           + ($signed({{(HB-HC){hc1_s2[r][HC-1]}}, hc1_s2[r]}) <<< (2*F));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[3] && vld_in[3]) begin
			for (int r = 0; r < TAPS; r++) begin
				hb_s3[r]  <= hb_d[r];
				hs1_s3[r] <= hs1_s2[r];
			end
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: e = b*f + 2*s1*D^3, floored to ROW_FRAC fraction bits
	// ------------------------------------------------------------------
	logic signed [F:0]    fxs_3;
	logic signed [HE-1:0] hpe_d  [TAPS];
	logic signed [HE-1:0] he_d   [TAPS];

	logic signed [VN-1:0] row_s4 [TAPS];
	logic [F-1:0]         fy_s4;

	assign fxs_3 = $signed({1'b0, fx_s3});

	always_comb begin
		for (int r = 0; r < TAPS; r++) begin
			hpe_d[r] = hb_s3[r] * fxs_3;
			he_d[r]  = hpe_d[r]
			           + ($signed({{(HE-HN){hs1_s3[r][HN-1]}}, hs1_s3[r]}) <<< (3*F + 1));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4] && vld_in[4]) begin
			for (int r = 0; r < TAPS; r++) begin
				// dropping low bits of a two's complement value floors it
				row_s4[r] <= he_d[r][H_SHIFT +: VN];
			end
			fy_s4 <= fy_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: vertical coefficients over the four row results
	// ------------------------------------------------------------------
	logic signed [VC-1:0] vx [TAPS];
	logic signed [VC-1:0] vc1_d;
	logic signed [VC-1:0] vc2_d;
	logic signed [VC-1:0] vc3_d;

	logic signed [VC-1:0] vc1_s5;
	logic signed [VC-1:0] vc2_s5;
	logic signed [VC-1:0] vc3_s5;
	logic signed [VN-1:0] vs1_s5;
	logic [F-1:0]         fy_s5;

	always_comb begin
		for (int j = 0; j < TAPS; j++) begin
			vx[j] = $signed({{(VC-VN){row_s4[j][VN-1]}}, row_s4[j]});
		end
		vc1_d = vx[2] - vx[0];
		vc2_d = (vx[0] <<< 1) - (vx[1] <<< 2) - vx[1] + (vx[2] <<< 2) - vx[3];
		vc3_d = vx[1] + (vx[1] <<< 1) - vx[0] - vx[2] - (vx[2] <<< 1) + vx[3];
	end

	always_ff @(posedge clk) begin
		if (rdy[5] && vld_in[5]) begin
			vc1_s5 <= vc1_d;
			vc2_s5 <= vc2_d;
			vc3_s5 <= vc3_d;
			vs1_s5 <= row_s4[1];
			fy_s5  <= fy_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 6: vertical a = c3*f + c2*D
	// ------------------------------------------------------------------
	logic signed [F:0]    fys_5;
	logic signed [VA-1:0] vpa_d;
	logic signed [VA-1:0] va_d;

	logic signed [VA-1:0] va_s6;
	logic signed [VC-1:0] vc1_s6;
	logic signed [VN-1:0] vs1_s6;
	logic [F-1:0]         fy_s6;

	assign fys_5 = $signed({1'b0, fy_s5});
	assign vpa_d = vc3_s5 * fys_5;
	assign va_d  = vpa_d + ($signed({{(VA-VC){vc2_s5[VC-1]}}, vc2_s5}) <<< F);

	always_ff @(posedge clk) begin
		if (rdy[6] && vld_in[6]) begin
			va_s6  <= va_d;
			vc1_s6 <= vc1_s5;
			vs1_s6 <= vs1_s5;
			fy_s6  <= fy_s5;
		end
	end

	// ------------------------------------------------------------------
	// stage 7: vertical b = a*f + c1*D^2
	// ------------------------------------------------------------------
	logic signed [F:0]    fys_6;
	logic signed [VB-1:0] vpb_d;
	logic signed [VB-1:0] vb_d;

	logic signed [VB-1:0] vb_s7;
	logic signed [VN-1:0] vs1_s7;
	logic [F-1:0]         fy_s7;

	assign fys_6 = $signed({1'b0, fy_s6});
	assign vpb_d = va_s6 * fys_6;
	assign vb_d  = vpb_d + ($signed({{(VB-VC){vc1_s6[VC-1]}}, vc1_s6}) <<< (2*F));

	always_ff @(posedge clk) begin
		if (rdy[7] && vld_in[7]) begin
			vb_s7  <= vb_d;
			vs1_s7 <= vs1_s6;
			fy_s7  <= fy_s6;
		end
	end

	// ------------------------------------------------------------------
	// stage 8: vertical e = b*f + 2*s1*D^3, floor to integer, clamp
	// ------------------------------------------------------------------
	logic signed [F:0]    fys_7;
	logic signed [VE-1:0] vpe_d;
	logic signed [VE-1:0] ve_d;
	logic                 neg_d;
	logic                 ovf_d;
	logic [S-1:0]         pix_d;

	logic [S-1:0]         pix_s8;

	assign fys_7 = $signed({1'b0, fy_s7});
	assign vpe_d = vb_s7 * fys_7;
	assign ve_d  = vpe_d + ($signed({{(VE-VN){vs1_s7[VN-1]}}, vs1_s7}) <<< (3*F + 1));

	// below zero clamps to zero, above full scale clamps to full scale
	assign neg_d = ve_d[VE-1];
	assign ovf_d = |ve_d[VE-2:V_SHIFT+S];

	always_comb begin
		if (neg_d) begin
			pix_d = '0;
		end else if (ovf_d) begin
			pix_d = PIX_MAX;
		end else begin
			pix_d = ve_d[V_SHIFT +: S];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[8] && vld_in[8]) begin
			pix_s8 <= pix_d;
		end
	end

	assign m_axis_tdata = OUT_W'(pix_s8);

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------

	// an empty output register means every stage can take data
	a_ready_when_drained: assert property (
		@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready
	) else $error("input refused while output stage empty");

	// a full stage 7 moves into a free output register
	a_last_stage_fills: assert property (
		@(posedge clk) disable iff (!arst_n)
		(vld_q[NST-1] && rdy[NST]) |=> m_axis_tvalid
	) else $error("stage 7 beat lost on the way to the output");

	// a blocked stage 1 keeps its beat and its data
	a_stage1_holds: assert property (
		@(posedge clk) disable iff (!arst_n)
		(vld_q[1] && !rdy[2]) |=> (vld_q[1] && $stable(hc2_s1[0]) && $stable(fy_s1))
	) else $error("stage 1 dropped or changed a stalled beat");

endmodule

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for the catmull-rom 4x4 bicubic interpolator
// depends on bci_pkg and bicubic_4x4_interpolator; needs nothing else to run
`timescale 1ns / 1ps

module testbench;
	import bci_pkg::*;

	localparam int SB          = SAMPLE_BITS_DEF;
	localparam int FB          = FRAC_BITS_DEF;
	localparam int IN_W        = ((16*SB + 2*FB + 7) / 8) * 8;
	localparam int OUT_W       = ((SB + 7) / 8) * 8;
	localparam longint PIX_MAX = (64'sd1 << SB) - 1;
	// shifts that floor the row sums and the final column sum
	localparam int unsigned ROW_SHIFT = 3*FB + 1 - ROW_FRAC;
	localparam int unsigned COL_SHIFT = 3*FB + 1 + ROW_FRAC;

	localparam real CLK_PERIOD   = 12.0;
	localparam int  RESET_CYCLES = 4;
	localparam int  TAIL_CYCLES  = 3 * NUM_STAGES;
	localparam int  PHASE_ITEMS  = 300;
	localparam int  REPORT_LIMIT = 10;

	// one window beat: last field in the lowest bits
	typedef struct packed {
		logic [FB-1:0]   y_frac;
		logic [FB-1:0]   x_frac;
		logic [4*SB-1:0] row_3;
		logic [4*SB-1:0] row_2;
		logic [4*SB-1:0] row_1;
		logic [4*SB-1:0] row_0;
	} window_t;

	// expected pixels, in order, worked out from each accepted window
	class pixel_scoreboard;
		logic [SB-1:0] expected_pixels[$];
		int            failures;

		// one catmull-rom cubic over four samples, exact, then floored by k bits
		function automatic longint cubic_floor(longint s0, longint s1, longint s2,
				longint s3, longint f, int unsigned k);
			longint d, d2, d3, f2, f3, acc;
			d   = 64'sd1 << FB;
			d2  = d * d;
			d3  = d2 * d;
			f2  = f * f;
			f3  = f2 * f;
			acc = s0 * (-f*d2 + 2*f2*d - f3)
				+ s1 * (2*d3 - 5*f2*d + 3*f3)
				+ s2 * (f*d2 + 4*f2*d - 3*f3)
				+ s3 * (-f2*d + f3);
			return acc >>> k;
		endfunction

		function automatic logic [SB-1:0] predict_pixel(window_t w);
			logic [4*SB-1:0] rr[4];
			longint          rowv[4];
			longint          v;
			rr = '{w.row_0, w.row_1, w.row_2, w.row_3};
			for (int r = 0; r < 4; r++) begin
				rowv[r] = cubic_floor(longint'(rr[r][0*SB +: SB]),
					longint'(rr[r][1*SB +: SB]), longint'(rr[r][2*SB +: SB]),
					longint'(rr[r][3*SB +: SB]), longint'(w.x_frac), ROW_SHIFT);
			end
			v = cubic_floor(rowv[0], rowv[1], rowv[2], rowv[3],
				longint'(w.y_frac), COL_SHIFT);
			if (v < 0)
				v = 0;
			else if (v > PIX_MAX)
				v = PIX_MAX;
			return v[SB-1:0];
		endfunction

		function void note_window(window_t w);
			expected_pixels.push_back(predict_pixel(w));
		endfunction

		function void check_pixel(logic [SB-1:0] got);
			logic [SB-1:0] want;
			if (expected_pixels.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected pixel beat: got %0d", got);
				return;
			end
			want = expected_pixels.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("pixel mismatch: expected %0d got %0d", want, got);
			end
		endfunction

		function int outstanding();
			return expected_pixels.size();
		endfunction

		// anything still waiting at the end never came out
		function void close_out();
			if (expected_pixels.size() != 0) begin
				failures += expected_pixels.size();
				$display("%0d expected pixels never arrived", expected_pixels.size());
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;  // row_0, row_1, row_2, row_3, x_frac, y_frac
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;       // pixel, zero fill

	// idle odds in percent for the window source and the pixel sink
	int src_idle_pct  = 17;
	int sink_idle_pct = 52;

	pixel_scoreboard sb;

	bicubic_4x4_interpolator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// sink stalls at random; the odds change per phase, zero means always ready
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// both monitors sample right at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_window(window_t'(s_axis_tdata));
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_pixel(m_axis_tdata[SB-1:0]);
	end

	// present one window, with random idle beats first, and hold it until taken;
	// tvalid stays high into the next call when that one does not idle
	task automatic send_window(input window_t w);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_W'(w);
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	function automatic window_t make_window(logic [4*SB-1:0] r0, logic [4*SB-1:0] r1,
			logic [4*SB-1:0] r2, logic [4*SB-1:0] r3, logic [FB-1:0] xf, logic [FB-1:0] yf);
		window_t w;
		w.row_0  = r0;
		w.row_1  = r1;
		w.row_2  = r2;
		w.row_3  = r3;
		w.x_frac = xf;
		w.y_frac = yf;
		return w;
	endfunction

	// random window: mostly free bits, some full-scale edges to drive the clamps,
	// some smooth patches close to real image content
	function automatic window_t random_window();
		window_t         w;
		logic [4*SB-1:0] rr[4];
		int              kind, base;
		kind = $urandom_range(9);
		base = $urandom_range(PIX_MAX);
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 4; j++) begin
				if (kind < 5)
					rr[r][j*SB +: SB] = SB'($urandom);
				else if (kind < 8)
					rr[r][j*SB +: SB] = $urandom_range(1) ? SB'(PIX_MAX) : '0;
				else
					rr[r][j*SB +: SB] = SB'((base + $urandom_range(16)) % (PIX_MAX + 1));
			end
		end
		w = make_window(rr[0], rr[1], rr[2], rr[3], FB'($urandom), FB'($urandom));
		// pin the fractions to their ends now and then
		case ($urandom_range(7))
			0: w.x_frac = '0;
			1: w.x_frac = '1;
			2: w.y_frac = '0;
			3: w.y_frac = '1;
			default: ;
		endcase
		return w;
	endfunction

	task automatic wait_drained();
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int src_pct, input int sink_pct);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_window(random_window());
	endtask

	task automatic run_directed();
		localparam logic [4*SB-1:0] ALL0 = '0;
		localparam logic [4*SB-1:0] ALL1 = '1;
		// full-scale rows that ring below zero and above full scale at mid fraction
		localparam logic [4*SB-1:0] DIP  = 32'hff0000ff;
		localparam logic [4*SB-1:0] BUMP = 32'h00ffff00;
		localparam logic [4*SB-1:0] RAMP = 32'h40302010;
		localparam logic [4*SB-1:0] LONE = 32'h0000ff00;
		// flat black and flat white at the fraction extremes
		send_window(make_window(ALL0, ALL0, ALL0, ALL0, 8'h00, 8'h00));
		send_window(make_window(ALL0, ALL0, ALL0, ALL0, 8'hff, 8'hff));
		send_window(make_window(ALL1, ALL1, ALL1, ALL1, 8'h00, 8'h00));
		send_window(make_window(ALL1, ALL1, ALL1, ALL1, 8'hff, 8'hff));
		send_window(make_window(ALL1, ALL1, ALL1, ALL1, 8'h80, 8'h80));
		// lone bright sample at the origin: zero fractions pick it exactly
		send_window(make_window(ALL0, LONE, ALL0, ALL0, 8'h00, 8'h00));
		send_window(make_window(ALL0, LONE, ALL0, ALL0, 8'hff, 8'hff));
		send_window(make_window(ALL0, LONE, ALL0, ALL0, 8'h01, 8'h01));
		// horizontal undershoot and overshoot, clamped low and high
		send_window(make_window(DIP, DIP, DIP, DIP, 8'h80, 8'h00));
		send_window(make_window(BUMP, BUMP, BUMP, BUMP, 8'h80, 8'h00));
		// the same down the columns
		send_window(make_window(ALL1, ALL0, ALL0, ALL1, 8'h00, 8'h80));
		send_window(make_window(ALL0, ALL1, ALL1, ALL0, 8'h00, 8'h80));
		// both directions at once
		send_window(make_window(DIP, BUMP, BUMP, DIP, 8'h80, 8'h80));
		send_window(make_window(BUMP, DIP, DIP, BUMP, 8'h80, 8'h80));
		// ramps at small, large and mixed fractions
		send_window(make_window(RAMP, RAMP, RAMP, RAMP, 8'h01, 8'h01));
		send_window(make_window(RAMP, RAMP, RAMP, RAMP, 8'hff, 8'h00));
		send_window(make_window(ALL0, 32'h10101010, 32'h20202020, 32'h30303030,
			8'h00, 8'hff));
		send_window(make_window(RAMP, DIP, ALL1, BUMP, 8'h55, 8'haa));
	endtask

	// hard stop if the handshakes hang
	initial begin
		#(CLK_PERIOD * 250000);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		sb = new;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// phase one: directed windows, then let the pipe run dry before random traffic
		run_directed();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait_drained();

		run_random(17, 52);
		run_random(52, 17);
		run_random(0, 0);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// all windows taken: wait for the last pixels, then watch for strays
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
hdl/bci_pkg.sv
hdl/bicubic_4x4_interpolator.sv
verif/testbench.sv
